[sv/b2nv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2nv_pkg
// Shared sizes, register indexes, color coefficients and the byte clamp for
// the BGRA to NV12 color converter.
// ----------------------------------------------------------------------------
package b2nv_pkg;

  // frame size limits and derived widths
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int CCNT_W     = $clog2(MAX_WIDTH);
  localparam int RCNT_W     = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int DIM_W      = 13;
  localparam int CMP_W      = ((DIM_W > CCNT_W) ? DIM_W : CCNT_W) + 1;
  localparam int RCMP_W     = ((DIM_W > RCNT_W) ? DIM_W : RCNT_W) + 1;

  // pixel and line store layout
  localparam int PIX_W  = 8;
  localparam int PAIR_W = PIX_W + 1;
  localparam int LSUM_W = 10;
  localparam int LINE_W = 3 * LSUM_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // luma coefficients, unsigned math
  localparam int YACC_W = 16;
  localparam logic [YACC_W-1:0] Y_R   = 16'd47;
  localparam logic [YACC_W-1:0] Y_G   = 16'd157;
  localparam logic [YACC_W-1:0] Y_B   = 16'd16;
  localparam logic [YACC_W-1:0] Y_RND = 16'd128;
  localparam logic [PIX_W-1:0]  Y_OFS = 8'd16;

  // chroma coefficients, signed math
  localparam int CACC_W = 17;
  localparam logic signed [CACC_W-1:0] CB_R  = -17'sd26;
  localparam logic signed [CACC_W-1:0] CB_G  = -17'sd87;
  localparam logic signed [CACC_W-1:0] CB_B  = 17'sd112;
  localparam logic signed [CACC_W-1:0] CR_R  = 17'sd112;
  localparam logic signed [CACC_W-1:0] CR_G  = -17'sd102;
  localparam logic signed [CACC_W-1:0] CR_B  = -17'sd10;
  localparam logic signed [CACC_W-1:0] C_RND = 17'sd128;
  localparam logic signed [CACC_W-1:0] C_OFS = 17'sd128;
  localparam logic signed [CACC_W-1:0] C_MAX = 17'sd255;

  function automatic logic [PIX_W-1:0] sat_byte(input logic signed [CACC_W-1:0] v);
    logic [PIX_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > C_MAX) begin
      res = '1;
    end else begin
      res = v[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

[sv/b2nv_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2nv_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module b2nv_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bgra_to_nv12_color_convert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgra_to_nv12_color_convert
// Streaming BGRA to 4:2:0 limited-range YCbCr converter with a line store.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock in raster order unless stalled and returns one
// registered result per pixel: its luma, and on the bottom-right pixel of
// each 2x2 block the block's Cb and Cr with chroma_valid set. The line store
// (one 30-bit entry per column pair, single port) is touched at most once per
// pixel: written on odd columns of even rows, read on odd columns of odd
// rows, so throughput is set by the input handshake alone. The line store is
// not cleared after reset; the first even row fills it before any read.
// frame_width and frame_height must be even and should be written only while
// no transfer is in flight; values above the maximum saturate.
module bgra_to_nv12_color_convert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [b2nv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [b2nv_pkg::DIM_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [b2nv_pkg::PIX_W-1:0]    blue_i,
  input  logic [b2nv_pkg::PIX_W-1:0]    green_i,
  input  logic [b2nv_pkg::PIX_W-1:0]    red_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [b2nv_pkg::PIX_W-1:0]    luma_o,
  output logic                          chroma_valid_o,
  output logic [b2nv_pkg::PIX_W-1:0]    cb_o,
  output logic [b2nv_pkg::PIX_W-1:0]    cr_o,
  output logic                          frame_end_o
);
  import b2nv_pkg::*;

  // configuration
  logic [DIM_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1920);
      height_q <= DIM_W'(1080);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_q, s2_valid_q;
  logic s2_ready, s1_ready, s1_adv, in_xfer;

  assign s2_ready   = !s2_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_xfer    = in_valid_i && s1_ready;

  // position and pair hold
  logic [CCNT_W-1:0]  col_q;
  logic [RCNT_W-1:0]  row_q;
  logic [3*PIX_W-1:0] hold_q;

  logic [CMP_W-1:0]  w_eff, col_next;
  logic [RCMP_W-1:0] h_eff, row_next;
  logic              row_end, frame_last;

  assign w_eff = (CMP_W'(width_q) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH)
                                                       : CMP_W'(width_q);
  assign h_eff = (RCMP_W'(height_q) > RCMP_W'(MAX_HEIGHT)) ? RCMP_W'(MAX_HEIGHT)
                                                           : RCMP_W'(height_q);
  assign col_next   = CMP_W'(col_q) + CMP_W'(1);
  assign row_next   = RCMP_W'(row_q) + RCMP_W'(1);
  assign row_end    = col_next >= w_eff;
  assign frame_last = row_end && (row_next >= h_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      hold_q <= '0;
    end else if (in_xfer) begin
      if (!col_q[0]) begin
        hold_q <= {red_i, green_i, blue_i};
      end
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_last ? '0 : row_next[RCNT_W-1:0];
      end else begin
        col_q <= col_next[CCNT_W-1:0];
      end
    end
  end

  // horizontal pair sums
  logic [PAIR_W-1:0] sum_b, sum_g, sum_r;
  assign sum_b = PAIR_W'(blue_i)  + PAIR_W'(hold_q[PIX_W-1:0]);
  assign sum_g = PAIR_W'(green_i) + PAIR_W'(hold_q[2*PIX_W-1:PIX_W]);
  assign sum_r = PAIR_W'(red_i)   + PAIR_W'(hold_q[3*PIX_W-1:2*PIX_W]);

  // line store: even rows write pair sums, odd rows read them back
  logic              line_we, line_re;
  logic [LINE_W-1:0] line_wdata, line_rdata;

  assign line_we    = in_xfer && col_q[0] && !row_q[0];
  assign line_re    = in_xfer && col_q[0] && row_q[0];
  assign line_wdata = {LSUM_W'(sum_r), LSUM_W'(sum_g), LSUM_W'(sum_b)};

  b2nv_ram #(
    .WIDTH(LINE_W),
    .DEPTH(LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .re_i    (line_re),
    .addr_i  (col_q[CCNT_W-1:1]),
    .wdata_i (line_wdata),
    .rdata_o (line_rdata)
  );

  // luma
  logic [YACC_W-1:0] y_acc;
  logic [PIX_W-1:0]  luma;
  assign y_acc = Y_R * YACC_W'(red_i) + Y_G * YACC_W'(green_i)
               + Y_B * YACC_W'(blue_i) + Y_RND;
  assign luma  = y_acc[YACC_W-1:YACC_W-PIX_W] + Y_OFS;

  // stage 1
  logic [PIX_W-1:0]  s1_luma_q;
  logic              s1_cv_q, s1_fe_q;
  logic [PAIR_W-1:0] s1_sb_q, s1_sg_q, s1_sr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_luma_q <= luma;
      s1_cv_q   <= col_q[0] && row_q[0];
      s1_fe_q   <= frame_last;
      s1_sb_q   <= sum_b;
      s1_sg_q   <= sum_g;
      s1_sr_q   <= sum_r;
    end
  end

  // 2x2 average and chroma
  logic [LSUM_W:0]         quad_b, quad_g, quad_r;
  logic signed [CACC_W-1:0] avg_b, avg_g, avg_r, cb_acc, cr_acc, cb_ofs, cr_ofs;
  logic [PIX_W-1:0]         cb, cr;

  assign quad_b = (LSUM_W+1)'(s1_sb_q) + (LSUM_W+1)'(line_rdata[LSUM_W-1:0]);
  assign quad_g = (LSUM_W+1)'(s1_sg_q) + (LSUM_W+1)'(line_rdata[2*LSUM_W-1:LSUM_W]);
  assign quad_r = (LSUM_W+1)'(s1_sr_q) + (LSUM_W+1)'(line_rdata[3*LSUM_W-1:2*LSUM_W]);
  assign avg_b  = CACC_W'(quad_b[PIX_W+1:2]);
  assign avg_g  = CACC_W'(quad_g[PIX_W+1:2]);
  assign avg_r  = CACC_W'(quad_r[PIX_W+1:2]);

  assign cb_acc = CB_R * avg_r + CB_G * avg_g + CB_B * avg_b + C_RND;
  assign cr_acc = CR_R * avg_r + CR_G * avg_g + CR_B * avg_b + C_RND;
  assign cb_ofs = (cb_acc >>> 8) + C_OFS;
  assign cr_ofs = (cr_acc >>> 8) + C_OFS;
  assign cb     = s1_cv_q ? sat_byte(cb_ofs) : '0;
  assign cr     = s1_cv_q ? sat_byte(cr_ofs) : '0;

  // output register
  logic [PIX_W-1:0] s2_luma_q, s2_cb_q, s2_cr_q;
  logic             s2_cv_q, s2_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_luma_q <= s1_luma_q;
      s2_cv_q   <= s1_cv_q;
      s2_cb_q   <= cb;
      s2_cr_q   <= cr;
      s2_fe_q   <= s1_fe_q;
    end
  end

  assign out_valid_o    = s2_valid_q;
  assign luma_o         = s2_luma_q;
  assign chroma_valid_o = s2_cv_q;
  assign cb_o           = s2_cb_q;
  assign cr_o           = s2_cr_q;
  assign frame_end_o    = s2_fe_q;

endmodule

[tb/bgra_to_nv12_color_convert_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgra_to_nv12_color_convert_tb
// Self-checking bench for the BGRA to NV12 converter. Streams pixels under
// random source gaps and sink stalls across a series of frame sizes, predicts
// luma, 2x2 chroma and frame end for every pixel, and checks each result in
// order.
// ----------------------------------------------------------------------------
module bgra_to_nv12_color_convert_tb;
  import b2nv_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic             chroma_valid;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic             frame_end;
  } nv12_sample_t;

  localparam int NUM_CORNERS = 14;
  // {red, green, blue}
  localparam logic [3*PIX_W-1:0] CORNER_RGB [NUM_CORNERS] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF, 24'h808080, 24'h7F7F7F, 24'h55AA55, 24'hAA55AA,
    24'h010101, 24'hFEFEFE
  };

  // tracks frame position, the pending pair and the even-row pair sums, and
  // holds the samples still owed by the block
  class nv12_sample_board;
    int unsigned        width_reg;
    int unsigned        height_reg;
    int unsigned        column;
    int unsigned        row;
    logic [3*PIX_W-1:0] held_pixel;
    logic [LINE_W-1:0]  pair_sums [LINE_DEPTH];
    nv12_sample_t       due_samples [$];
    int                 mismatches;

    function new();
      width_reg  = 1920;
      height_reg = 1080;
      column     = 0;
      row        = 0;
      held_pixel = '0;
      mismatches = 0;
      foreach (pair_sums[i]) pair_sums[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = value;
      end else if (idx == REG_FRAME_HEIGHT) begin
        height_reg = value;
      end
    endfunction

    function logic [PIX_W-1:0] clip_to_byte(int v);
      if (v < 0) return '0;
      if (v > 255) return '1;
      return v[PIX_W-1:0];
    endfunction

    function void take_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                             logic [PIX_W-1:0] r);
      int unsigned       eff_w, eff_h, pidx;
      int                ib, ig, ir, sum_b, sum_g, sum_r, avg_b, avg_g, avg_r, acc;
      logic [LINE_W-1:0] stored;
      logic              row_end;
      nv12_sample_t      s;
      eff_w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      eff_h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      ib = b;
      ig = g;
      ir = r;
      s = '0;
      row_end = (column + 1) >= eff_w;
      s.frame_end = row_end && ((row + 1) >= eff_h);
      s.luma = clip_to_byte(((47 * ir + 157 * ig + 16 * ib + 128) >>> 8) + 16);
      pidx = column >> 1;
      if (column % 2 == 0) begin
        held_pixel = {r, g, b};
      end else begin
        sum_b = ib + held_pixel[PIX_W-1:0];
        sum_g = ig + held_pixel[2*PIX_W-1:PIX_W];
        sum_r = ir + held_pixel[3*PIX_W-1:2*PIX_W];
        if (row % 2 == 0) begin
          pair_sums[pidx] = {sum_r[LSUM_W-1:0], sum_g[LSUM_W-1:0], sum_b[LSUM_W-1:0]};
        end else begin
          stored = pair_sums[pidx];
          avg_b = (sum_b + stored[LSUM_W-1:0]) >> 2;
          avg_g = (sum_g + stored[2*LSUM_W-1:LSUM_W]) >> 2;
          avg_r = (sum_r + stored[3*LSUM_W-1:2*LSUM_W]) >> 2;
          s.chroma_valid = 1'b1;
          acc = (-26 * avg_r - 87 * avg_g + 112 * avg_b + 128) >>> 8;
          s.cb = clip_to_byte(acc + 128);
          acc = (112 * avg_r - 102 * avg_g - 10 * avg_b + 128) >>> 8;
          s.cr = clip_to_byte(acc + 128);
        end
      end
      if (row_end) begin
        column = 0;
        row = s.frame_end ? 0 : row + 1;
      end else begin
        column++;
      end
      due_samples.push_back(s);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_sample(nv12_sample_t got);
      nv12_sample_t want;
      if (due_samples.size() == 0) begin
        $display("%0t: result with nothing expected, luma %0d", $time, got.luma);
        mismatches++;
        return;
      end
      want = due_samples.pop_front();
      compare_field("luma", want.luma, got.luma);
      compare_field("chroma_valid", want.chroma_valid, got.chroma_valid);
      compare_field("cb", want.cb, got.cb);
      compare_field("cr", want.cr, got.cr);
      compare_field("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_FRAME_WIDTH;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  logic [PIX_W-1:0]     blue = '0;
  logic [PIX_W-1:0]     green = '0;
  logic [PIX_W-1:0]     red = '0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     luma_o;
  logic                 chroma_valid_o;
  logic [PIX_W-1:0]     cb_o;
  logic [PIX_W-1:0]     cr_o;
  logic                 frame_end_o;
  bit                   quiet = 1'b0;

  nv12_sample_board board;

  bgra_to_nv12_color_convert DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .blue_i         (blue),
    .green_i        (green),
    .red_i          (red),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .luma_o         (luma_o),
    .chroma_valid_o (chroma_valid_o),
    .cb_o           (cb_o),
    .cr_o           (cr_o),
    .frame_end_o    (frame_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 38);
  end

  // input transfer is noted before the output check so any latency works
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) board.set_reg(cfg_idx, cfg_data);
      if (in_valid && !in_stall_o) board.take_pixel(blue, green, red);
      if (out_valid_o && !out_stall) begin
        board.check_sample({luma_o, chroma_valid_o, cb_o, cr_o, frame_end_o});
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] r);
    while (!quiet && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    blue     <= b;
    green    <= g;
    red      <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [PIX_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count) send_pixel(pick_byte(), pick_byte(), pick_byte());
  endtask

  // width may only change on an even row, so odd rows never read a pair
  // that the row above did not store
  task automatic finish_odd_row();
    while (board.row % 2 != 0) send_random(1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.due_samples.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= DIM_W'(value);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  initial begin
    board = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corner colors at reset size, then random pixels along row 0
    foreach (CORNER_RGB[i]) begin
      send_pixel(CORNER_RGB[i][7:0], CORNER_RGB[i][15:8], CORNER_RGB[i][23:16]);
    end
    send_random(64 - NUM_CORNERS);
    settle();

    // one pixel per row: three four-row frames, ending back on row 0
    set_size(1, 4);
    send_random(12);
    settle();

    // full small frame with no gaps; corner colors as 2x2 blocks on top
    set_size(32, 8);
    quiet = 1'b1;
    for (int rr = 0; rr < 2; rr++) begin
      for (int cc = 0; cc < 32; cc++) begin
        if (cc < 2 * NUM_CORNERS) begin
          send_pixel(CORNER_RGB[cc/2][7:0], CORNER_RGB[cc/2][15:8],
                     CORNER_RGB[cc/2][23:16]);
        end else begin
          send_random(1);
        end
      end
    end
    send_random(32 * 8 - 64);
    quiet = 1'b0;
    settle();

    // sizes beyond the limit saturate
    set_size(8191, 8191);
    send_random(60);
    settle();

    // size changes mid-frame, including degenerate and saturated sizes
    for (int p = 0; p < 14; p++) begin
      int unsigned w, h;
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 1);
        1: w = 64;
        default: w = $urandom_range(2, 16);
      endcase
      case ($urandom_range(0, 9))
        0: h = $urandom_range(0, 2);
        1: h = 8191;
        default: h = $urandom_range(2, 8);
      endcase
      set_size(w, h);
      send_random($urandom_range(15, 35));
      finish_odd_row();
      settle();
    end

    repeat (10) @(negedge clk_i);
    if (board.mismatches == 0 && board.due_samples.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
sv/b2nv_pkg.sv
sv/b2nv_ram.sv
sv/bgra_to_nv12_color_convert.sv
tb/bgra_to_nv12_color_convert_tb.sv
